>>> src/tick_task_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Tick task scheduler assertion macros
// Shorthand for the concurrent checks that the scheduler core carries.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_SCHEDULER_CORE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared types and constants for the scheduler core and its slot unit.
// ----------------------------------------------------------------------------
package tts_pkg;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_ADD_PERIODIC = 2'd1,
    OP_ADD_ONESHOT  = 2'd2,
    OP_SERVICE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_IDLE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_VISIT,
    S_REPLY
  } state_t;

  // A service request never dispatches more than this many runs.
  localparam int MAX_DISPATCH = 16;
  localparam int DISP_W       = 5;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] countdown;
    logic [15:0] reload;
    logic [7:0]  pending;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_t       kind;
    logic        accepted;
    logic [3:0]  slot;
    logic [7:0]  run_id;
    logic [4:0]  fired;
  } result_t;

  typedef struct packed {
    logic write;
    logic expired;
    logic dispatch;
    logic free_slot;
  } alu_stat_t;

endpackage

>>> src/tts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/tts_slot_alu.sv
// ----------------------------------------------------------------------------
// Tick task scheduler slot unit
// Updates one table entry for a tick or a service pass.
// ----------------------------------------------------------------------------
module tts_slot_alu (
  input  logic               is_tick,
  input  logic               occupied,
  input  tts_pkg::entry_t    rd,
  output tts_pkg::entry_t    wr,
  output tts_pkg::alu_stat_t stat
);

  always_comb begin
    wr   = rd;
    stat = '0;
    if (occupied) begin
      if (is_tick) begin
        if (rd.countdown != 16'd0) begin
          stat.write   = 1'b1;
          wr.countdown = rd.countdown - 16'd1;
          if (rd.countdown == 16'd1) begin
            // Expiry: count the run and reload; a one-shot reloads zero.
            stat.expired = 1'b1;
            wr.countdown = rd.reload;
            if (rd.pending != 8'hFF) begin
              wr.pending = rd.pending + 8'd1;
            end
          end
        end
      end else if (rd.pending != 8'd0) begin
        stat.write    = 1'b1;
        stat.dispatch = 1'b1;
        wr.pending    = rd.pending - 8'd1;
        if (rd.pending == 8'd1 && rd.reload == 16'd0) begin
          stat.free_slot = 1'b1;
        end
      end
    end
  end

endmodule

>>> src/tick_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// Tick task scheduler core
// Table of periodic and one-shot task slots driven by tick, add and service
// requests, with one slot visited per cycle unless the pass stalls.
// ----------------------------------------------------------------------------
// The core takes one request at a time and holds in_ready low until its
// final result has been loaded into the output register; in_ready rises in
// the cycle right after that load. Slot contents live in a single-read-port
// RAM and are visited one slot per cycle, unless a held dispatch stalls the
// pass, by a shared slot update unit. A service pass can end before the
// last slot once it has sixteen dispatches. An add scans the occupancy
// flags in slot order and claims the lowest free slot, if there is one. An
// add with a zero task id or a zero period is refused without a scan. A
// result that is due while the output register still holds an unaccepted
// one waits until the register has room. Occupancy is kept in flip-flops
// cleared by reset, so no clearing pass is needed. A service request
// dispatches, in slot order, at most sixteen runs, one per slot with
// pending work; last marks the final result of every request.
// ----------------------------------------------------------------------------
module tick_task_scheduler_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  task_id,
  input  logic [15:0] period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        accepted,
  output logic [3:0]  slot,
  output logic [7:0]  run_id,
  output logic [4:0]  fired,
  output logic        last
);

`include "tick_task_scheduler_core_assert.svh"

  localparam int IDX_W = $clog2(SLOTS);

  tts_pkg::state_t state, state_next;
  tts_pkg::op_t    cur_op;
  logic [7:0]      cur_id;
  logic [15:0]     cur_period;
  logic [IDX_W-1:0] idx;
  logic [SLOTS-1:0] occ;
  logic [4:0]      fired_cnt;
  logic [tts_pkg::DISP_W-1:0] disp_cnt;
  tts_pkg::result_t res;
  logic            res_full;

  // Table RAM ports.
  logic                   ram_we;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  tts_pkg::entry_t        ram_wdata;
  tts_pkg::entry_t        ram_rdata;

  tts_pkg::entry_t        alu_wr;
  tts_pkg::alu_stat_t     stat;
  tts_pkg::entry_t        new_entry;

  logic in_fire;
  logic can_push;
  logic is_tick;
  logic idx_last;
  logic add_ok;
  logic in_is_visit;
  logic scan_hit;
  logic stall;
  logic visit_done;
  logic push_mid;
  logic push_end;
  logic [4:0] fired_inc;
  logic [IDX_W+3:0] idx_wide;
  logic [3:0] idx_slot;

  tts_ram #(
    .WIDTH (tts_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tts_slot_alu u_alu (
    .is_tick  (is_tick),
    .occupied (occ[idx]),
    .rd       (ram_rdata),
    .wr       (alu_wr),
    .stat     (stat)
  );

  assign in_fire     = in_valid && in_ready;
  assign can_push    = !out_valid || out_ready;
  assign is_tick     = cur_op == tts_pkg::OP_TICK;
  assign idx_last    = idx == IDX_W'(SLOTS - 1);
  assign add_ok      = task_id != 8'd0 && period != 16'd0;
  assign in_is_visit = op == tts_pkg::OP_TICK || op == tts_pkg::OP_SERVICE;
  assign scan_hit    = !occ[idx];
  assign idx_wide    = {4'b0000, idx};
  assign idx_slot    = idx_wide[3:0];

  // A dispatch found while an earlier one is still held waits for room in
  // the output register; nothing else in the pass can stall.
  assign stall      = state == tts_pkg::S_VISIT && stat.dispatch && res_full && !can_push;
  assign visit_done = idx_last ||
                      (stat.dispatch && disp_cnt == tts_pkg::DISP_W'(tts_pkg::MAX_DISPATCH - 1));
  assign fired_inc  = (stat.expired && fired_cnt != 5'd31) ? fired_cnt + 5'd1 : fired_cnt;

  assign push_mid = state == tts_pkg::S_VISIT && !stall && stat.dispatch && res_full;
  assign push_end = state == tts_pkg::S_REPLY && can_push;

  always_comb begin
    new_entry.task_id   = cur_id;
    new_entry.countdown = cur_period;
    new_entry.reload    = (cur_op == tts_pkg::OP_ADD_PERIODIC) ? cur_period : 16'd0;
    new_entry.pending   = 8'd0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tts_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_is_visit) begin
            state_next = tts_pkg::S_VISIT;
          end else if (add_ok) begin
            state_next = tts_pkg::S_SCAN;
          end else begin
            state_next = tts_pkg::S_REPLY;
          end
        end
      end
      tts_pkg::S_SCAN: begin
        if (scan_hit || idx_last) begin
          state_next = tts_pkg::S_REPLY;
        end
      end
      tts_pkg::S_VISIT: begin
        if (!stall && visit_done) begin
          state_next = tts_pkg::S_REPLY;
        end
      end
      tts_pkg::S_REPLY: begin
        if (can_push) begin
          state_next = tts_pkg::S_IDLE;
        end
      end
      default: state_next = tts_pkg::S_IDLE;
    endcase
  end

  // Handshake and table port controls.
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx + IDX_W'(1);
    ram_we    = 1'b0;
    ram_wdata = alu_wr;
    unique case (state)
      tts_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ram_re    = in_fire && in_is_visit;
        ram_raddr = '0;
      end
      tts_pkg::S_SCAN: begin
        ram_we    = scan_hit;
        ram_wdata = new_entry;
      end
      tts_pkg::S_VISIT: begin
        ram_we = !stall && stat.write;
        ram_re = !stall && !visit_done;
      end
      tts_pkg::S_REPLY: begin
        ram_re = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tts_pkg::S_IDLE;
      occ       <= '0;
      disp_cnt  <= '0;
      res_full  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      unique case (state)
        tts_pkg::S_IDLE: begin
          if (in_fire) begin
            cur_op     <= tts_pkg::op_t'(op);
            cur_id     <= task_id;
            cur_period <= period;
            idx        <= '0;
            fired_cnt  <= 5'd0;
            disp_cnt   <= '0;
            res_full   <= 1'b0;
            res        <= '{kind: tts_pkg::KIND_ADD, accepted: 1'b0, slot: 4'd0,
                            run_id: 8'd0, fired: 5'd0};
          end
        end
        tts_pkg::S_SCAN: begin
          if (scan_hit) begin
            occ[idx] <= 1'b1;
            res      <= '{kind: tts_pkg::KIND_ADD, accepted: 1'b1, slot: idx_slot,
                          run_id: 8'd0, fired: 5'd0};
          end else if (!idx_last) begin
            idx <= idx + IDX_W'(1);
          end
        end
        tts_pkg::S_VISIT: begin
          if (!stall) begin
            fired_cnt <= fired_inc;
            if (stat.free_slot) begin
              occ[idx] <= 1'b0;
            end
            // The newest dispatch is held back until the pass knows
            // whether another one follows it.
            if (stat.dispatch) begin
              res      <= '{kind: tts_pkg::KIND_DISPATCH, accepted: 1'b0, slot: idx_slot,
                            run_id: ram_rdata.task_id, fired: 5'd0};
              res_full <= 1'b1;
              disp_cnt <= disp_cnt + tts_pkg::DISP_W'(1);
            end
            if (visit_done) begin
              if (is_tick) begin
                res <= '{kind: tts_pkg::KIND_TICK, accepted: 1'b0, slot: 4'd0,
                         run_id: 8'd0, fired: fired_inc};
              end else if (!stat.dispatch && !res_full) begin
                res <= '{kind: tts_pkg::KIND_IDLE, accepted: 1'b0, slot: 4'd0,
                         run_id: 8'd0, fired: 5'd0};
              end
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        tts_pkg::S_REPLY: begin
          if (can_push) begin
            res_full <= 1'b0;
          end
        end
        default: begin
          res_full <= 1'b0;
        end
      endcase

      if (push_mid || push_end) begin
        out_valid <= 1'b1;
        kind      <= res.kind;
        accepted  <= res.accepted;
        slot      <= res.slot;
        run_id    <= res.run_id;
        fired     <= res.fired;
        last      <= push_end;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TTS_ASSERT_NEXT(a_busy_after_accept,
                   in_valid && in_ready, !in_ready, "request accepted while busy")
  `TTS_ASSERT_NEXT(a_add_claims_one_slot,
                   state == tts_pkg::S_SCAN && !occ[idx],
                   $countones(occ) == $past($countones(occ)) + 1,
                   "add did not claim exactly one slot")
  `TTS_ASSERT_NOW(a_dispatch_cap,
                  1'b1, disp_cnt <= tts_pkg::DISP_W'(tts_pkg::MAX_DISPATCH),
                  "service pass exceeded its dispatch limit")
  `TTS_ASSERT_NOW(a_fired_bound,
                  out_valid && kind == tts_pkg::KIND_TICK, fired <= SLOTS,
                  "tick reported more expiries than slots")

endmodule

>>> verif/tick_task_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick task scheduler checker
// Tracks the slot table through every accepted request and compares each
// result the core returns, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module tick_task_scheduler_checker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  task_id,
  input  logic [15:0] period,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic        accepted,
  input  logic [3:0]  slot,
  input  logic [7:0]  run_id,
  input  logic [4:0]  fired,
  input  logic        last,
  output int          mismatches,
  output int          replies_due
);

  typedef struct {
    tts_pkg::kind_t kind;
    logic        accepted;
    logic [3:0]  slot;
    logic [7:0]  run_id;
    logic [4:0]  fired;
    logic        last;
  } reply_t;

  // Shadow copy of the slot table.
  logic [7:0]  task_of   [SLOTS];
  logic [15:0] count_of  [SLOTS];
  logic [15:0] reload_of [SLOTS];
  logic [7:0]  runs_of   [SLOTS];

  reply_t reply_queue[$];

  initial begin
    mismatches  = 0;
    replies_due = 0;
  end

  task automatic flag(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void push_reply(input tts_pkg::kind_t k, input logic acc,
                                     input logic [3:0] s,
                                     input logic [7:0] id, input logic [4:0] f,
                                     input logic l);
    reply_t r;
    r.kind     = k;
    r.accepted = acc;
    r.slot     = s;
    r.run_id   = id;
    r.fired    = f;
    r.last     = l;
    reply_queue.push_back(r);
  endfunction

  function automatic void compute_replies(input tts_pkg::op_t o, input logic [7:0] id,
                                          input logic [15:0] per);
    int n_fired;
    int n_sent;
    int free_at;
    n_fired = 0;
    n_sent  = 0;
    free_at = -1;
    case (o)
      tts_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (task_of[i] != 0 && count_of[i] != 0) begin
            count_of[i] = count_of[i] - 16'd1;
            if (count_of[i] == 0) begin
              if (runs_of[i] != 8'hFF) runs_of[i] = runs_of[i] + 8'd1;
              if (n_fired < 31) n_fired++;
              if (reload_of[i] != 0) count_of[i] = reload_of[i];
            end
          end
        end
        push_reply(tts_pkg::KIND_TICK, 1'b0, 4'd0, 8'd0, n_fired[4:0], 1'b1);
      end
      tts_pkg::OP_ADD_PERIODIC, tts_pkg::OP_ADD_ONESHOT: begin
        if (id != 0 && per != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (free_at < 0 && task_of[i] == 0) free_at = i;
          end
        end
        if (free_at >= 0) begin
          task_of[free_at]   = id;
          count_of[free_at]  = per;
          reload_of[free_at] = (o == tts_pkg::OP_ADD_PERIODIC) ? per : 16'd0;
          runs_of[free_at]   = 8'd0;
          push_reply(tts_pkg::KIND_ADD, 1'b1, free_at[3:0], 8'd0, 5'd0, 1'b1);
        end else begin
          push_reply(tts_pkg::KIND_ADD, 1'b0, 4'd0, 8'd0, 5'd0, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (n_sent < tts_pkg::MAX_DISPATCH && task_of[i] != 0 && runs_of[i] != 0) begin
            push_reply(tts_pkg::KIND_DISPATCH, 1'b0, i[3:0], task_of[i], 5'd0, 1'b0);
            n_sent++;
            runs_of[i] = runs_of[i] - 8'd1;
            // A drained one-shot task gives its slot back.
            if (runs_of[i] == 0 && reload_of[i] == 0) begin
              task_of[i]  = 8'd0;
              count_of[i] = 16'd0;
            end
          end
        end
        if (n_sent == 0) push_reply(tts_pkg::KIND_IDLE, 1'b0, 4'd0, 8'd0, 5'd0, 1'b1);
        else reply_queue[$].last = 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        task_of[i]   = 8'd0;
        count_of[i]  = 16'd0;
        reload_of[i] = 16'd0;
        runs_of[i]   = 8'd0;
      end
      reply_queue.delete();
    end else begin
      if (in_valid && in_ready) compute_replies(tts_pkg::op_t'(op), task_id, period);
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          flag($sformatf("result of kind %0d with no request outstanding", kind));
        end else begin
          want = reply_queue.pop_front();
          if (kind !== want.kind)
            flag($sformatf("kind got %0d, want %0d", kind, want.kind));
          if (accepted !== want.accepted)
            flag($sformatf("accepted got %0d, want %0d", accepted, want.accepted));
          if (slot !== want.slot)
            flag($sformatf("slot got %0d, want %0d", slot, want.slot));
          if (run_id !== want.run_id)
            flag($sformatf("run_id got %0d, want %0d", run_id, want.run_id));
          if (fired !== want.fired)
            flag($sformatf("fired got %0d, want %0d", fired, want.fired));
          if (last !== want.last)
            flag($sformatf("last got %0d, want %0d", last, want.last));
        end
      end
    end
    replies_due <= reply_queue.size();
  end

endmodule

>>> verif/tick_task_scheduler_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick task scheduler core testbench
// Drives tick, add and service requests into the core with random gaps and
// output stalls, and lets the checker predict and compare every result.
// ----------------------------------------------------------------------------
module tick_task_scheduler_core_test;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [7:0]  task_id;
  logic [15:0] period;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic        accepted;
  logic [3:0]  slot;
  logic [7:0]  run_id;
  logic [4:0]  fired;
  logic        last;

  int mismatches;
  int replies_due;
  int cycles     = 0;
  int burst_left = 0;

  tick_task_scheduler_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .task_id(task_id),
    .period(period),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .accepted(accepted),
    .slot(slot),
    .run_id(run_id),
    .fired(fired),
    .last(last)
  );

  tick_task_scheduler_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .task_id(task_id),
    .period(period),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .accepted(accepted),
    .slot(slot),
    .run_id(run_id),
    .fired(fired),
    .last(last),
    .mismatches(mismatches),
    .replies_due(replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a run that hangs or loses results ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. The sender
  // works in bursts: valid stays high across a burst, and between bursts it
  // drops for a random gap. A gap of zero gives long unbroken stretches.
  task automatic offer(input tts_pkg::op_t o, input logic [7:0] id,
                       input logic [15:0] per);
    int gap;
    op       <= o;
    task_id  <= id;
    period   <= per;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The receiver runs through windows of random length, each with its own
  // stall rate. The fifth window is one long hold-off: the core's output
  // register fills, in_ready drops, and the sender keeps offering meanwhile.
  initial begin
    int stall_pct;
    int span;
    out_ready <= 1'b0;
    @(negedge rst);
    for (int w = 0; ; w++) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
      span = $urandom_range(20, 80);
      if (w == 4) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        repeat (span) begin
          out_ready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int pick;
    int periodic_left;
    int large_left;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    op       <= tts_pkg::OP_TICK;
    task_id  <= 8'd0;
    period   <= 16'd0;
    periodic_left = 3;
    large_left    = 2;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The table starts empty, so a service has nothing to do,
    // and adds with a zero id or a zero period are turned away.
    offer(tts_pkg::OP_SERVICE, 8'd0, 16'd0);
    offer(tts_pkg::OP_ADD_PERIODIC, 8'd0, 16'd5);
    offer(tts_pkg::OP_ADD_ONESHOT, 8'd7, 16'd0);
    offer(tts_pkg::OP_TICK, 8'hFF, 16'hFFFF);
    // Slot 0 gets the widest period and never expires within the run;
    // slot 1 is a fast periodic task that stays for good.
    offer(tts_pkg::OP_ADD_PERIODIC, 8'hFF, 16'hFFFF);
    offer(tts_pkg::OP_ADD_PERIODIC, 8'd1, 16'd2);
    for (int i = 2; i < SLOTS; i++) offer(tts_pkg::OP_ADD_ONESHOT, 8'(i * 17), 16'd1);
    // Every slot is taken now, so this add must be refused.
    offer(tts_pkg::OP_ADD_ONESHOT, 8'd200, 16'd3);
    // The first tick expires all one-shot tasks, the second the periodic one.
    offer(tts_pkg::OP_TICK, 8'd0, 16'd0);
    offer(tts_pkg::OP_TICK, 8'd0, 16'd0);
    // A service that dispatches from almost every slot, then one with
    // nothing left; the drained one-shot slots become free again.
    offer(tts_pkg::OP_SERVICE, 8'd0, 16'd0);
    offer(tts_pkg::OP_SERVICE, 8'd0, 16'd0);

    // Random part. Most adds are short one-shot tasks, which free their
    // slots once fired and serviced, so the table keeps turning over.
    // Periodic tasks and one-shots with huge periods hold a slot for the
    // rest of the run, so only a few are let in.
    for (int n = 0; n < 80; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        offer(tts_pkg::OP_TICK, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)));
      end else if (pick < 66) begin
        offer(tts_pkg::OP_ADD_ONESHOT, 8'($urandom_range(1, 255)),
              16'($urandom_range(1, 8)));
      end else if (pick < 84) begin
        offer(tts_pkg::OP_SERVICE, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)));
      end else if (pick < 88 && periodic_left > 0) begin
        periodic_left--;
        offer(tts_pkg::OP_ADD_PERIODIC, 8'($urandom_range(1, 255)),
              16'($urandom_range(1, 6)));
      end else if (pick < 90 && large_left > 0) begin
        large_left--;
        offer(tts_pkg::OP_ADD_ONESHOT, 8'($urandom_range(1, 255)),
              16'($urandom_range(16'h8000, 16'hFFFF)));
      end else if (pick < 95) begin
        // Refused add: zero id with any period.
        offer($urandom_range(0, 1) ? tts_pkg::OP_ADD_PERIODIC : tts_pkg::OP_ADD_ONESHOT,
              8'd0, 16'($urandom_range(0, 65535)));
      end else begin
        // Refused add: zero period with any id.
        offer($urandom_range(0, 1) ? tts_pkg::OP_ADD_PERIODIC : tts_pkg::OP_ADD_ONESHOT,
              8'($urandom_range(0, 255)), 16'd0);
      end
    end

    // Drain the short one-shot tasks, then let a period-one task run
    // unserviced until its pending count saturates.
    repeat (10) offer(tts_pkg::OP_TICK, 8'd0, 16'd0);
    repeat (2) offer(tts_pkg::OP_SERVICE, 8'd0, 16'd0);
    offer(tts_pkg::OP_ADD_PERIODIC, 8'hA5, 16'd1);
    repeat (262) offer(tts_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)));
    repeat (3) offer(tts_pkg::OP_SERVICE, 8'd0, 16'd0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    if (mismatches == 0 && replies_due == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
